// ----- rtl/core/ffha_pkg.sv -----
// Shared codes for the first-fit heap allocator: opcodes, status and block markers.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    // Scratch width for size and offset arithmetic (requests are 16 bits).
    localparam int unsigned CALC_W = 18;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FAIL     = 2'd1,
        STAT_NOT_USED = 2'd2,
        STAT_RSVD     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MK_NONE = 2'd0,
        MK_FREE = 2'd1,
        MK_USED = 2'd2,
        MK_RSVD = 2'd3
    } marker_t;

endpackage

`default_nettype wire

// ----- rtl/core/first_fit_heap_allocator.sv -----
// First-fit heap allocator: sequencer around per-granule block and free-list memories.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                                          Direction
// -------  ---------------------------------------------  ---------
// request  s_valid s_ready s_opcode s_request_bytes        in
//          s_data_offset
// result   m_valid m_ready m_status m_result_offset        out
//
// One request beat in flight at a time; each beat yields one result beat.
// Allocate walks the free list, reading each node, then unlinks the first block that
// fits, marks it used and, for a split, pushes the remainder as a free block. Free
// checks the marker, pushes the block to the list head and runs a coalesce pass that
// merges each visited block with a free block that starts at its end. The memory read
// port (one access a cycle, registered read) sets the pace. After reset a clearing pass
// writes every granule entry (1024 by default) with s_ready low.
// A result beat waits in the output register; the next request beat is taken
// while it waits, and the sequencer holds before its own result until the
// register is free.

module first_fit_heap_allocator #(
    parameter int unsigned HEAP_BYTES      = 8192,
    parameter int unsigned ALIGN_BYTES     = 8,
    parameter int unsigned MIN_BLOCK_BYTES = 32,
    parameter int unsigned HEADER_BYTES    = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [0:0]  s_opcode,
    input  wire logic [15:0] s_request_bytes,
    input  wire logic [12:0] s_data_offset,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [12:0]      m_result_offset
);
    import ffha_pkg::*;

    localparam int unsigned GRANULES = HEAP_BYTES / ALIGN_BYTES;
    localparam int unsigned GW       = $clog2(GRANULES);
    localparam int unsigned LKW      = $clog2(GRANULES + 1);
    localparam int unsigned LW       = $clog2(HEAP_BYTES + 1);
    localparam int unsigned GDW      = $clog2(GRANULES + 2);
    localparam int unsigned MIN_EFF  =
        ((MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

    localparam logic [LKW-1:0]    NIL      = LKW'(GRANULES);
    localparam logic [GDW-1:0]    GUARD_MX = GDW'(GRANULES);
    localparam logic [GW-1:0]     LAST_G   = GW'(GRANULES - 1);
    localparam logic [CALC_W-1:0] C_ALIGN  = CALC_W'(ALIGN_BYTES);
    localparam logic [CALC_W-1:0] C_HDR    = CALC_W'(HEADER_BYTES);
    localparam logic [CALC_W-1:0] C_MIN    = CALC_W'(MIN_EFF);
    localparam logic [CALC_W-1:0] C_HEAP   = CALC_W'(HEAP_BYTES);
    localparam logic [CALC_W-1:0] C_GRAN   = CALC_W'(GRANULES);

    typedef enum logic [17:0] {
        S_CLEAR  = 18'h00001,
        S_IDLE   = 18'h00002,
        S_DECODE = 18'h00004,
        S_A_RD   = 18'h00008,
        S_A_CHK  = 18'h00010,
        S_A_UL1  = 18'h00020,
        S_A_UL2  = 18'h00040,
        S_A_SP1  = 18'h00080,
        S_A_SP2  = 18'h00100,
        S_F_CHK  = 18'h00200,
        S_F_P2   = 18'h00400,
        S_C_RD   = 18'h00800,
        S_C_CHK  = 18'h01000,
        S_C_TCHK = 18'h02000,
        S_C_M1   = 18'h04000,
        S_C_M2   = 18'h08000,
        S_RESP   = 18'h10000,
        S_SPARE  = 18'h20000
    } state_t;

    // Per-granule stores: start marker, block length, free-list links.
    logic [1:0]     mem_mk [GRANULES];
    logic [LW-1:0]  mem_ln [GRANULES];
    logic [LKW-1:0] mem_nx [GRANULES];
    logic [LKW-1:0] mem_pv [GRANULES];

    logic [1:0]     rd_mk_reg;
    logic [LW-1:0]  rd_ln_reg;
    logic [LKW-1:0] rd_nx_reg;
    logic [LKW-1:0] rd_pv_reg;

    logic [GW-1:0]  rd_addr;
    logic           we_mk, we_ln, we_nx, we_pv;
    logic [GW-1:0]  wa_mk, wa_ln, wa_nx, wa_pv;
    logic [1:0]     wd_mk;
    logic [LW-1:0]  wd_ln;
    logic [LKW-1:0] wd_nx, wd_pv;

    // Control state.
    state_t         state_reg, state_next;
    logic [GW-1:0]  clr_reg, clr_next;
    logic [LKW-1:0] head_reg, head_next;
    logic           m_valid_reg, m_valid_next;

    // Working payload.
    logic [0:0]        op_reg, op_next;
    logic [15:0]       req_reg, req_next;
    logic [12:0]       doff_reg, doff_next;
    logic [CALC_W-1:0] need_reg, need_next;
    logic [LKW-1:0]    cur_reg, cur_next;
    logic [GDW-1:0]    guard_reg, guard_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [LW-1:0]     tlen_reg, tlen_next;
    logic [LKW-1:0]    p_reg, p_next;
    logic [LKW-1:0]    n_reg, n_next;
    logic [LKW-1:0]    t_reg, t_next;
    logic [LKW-1:0]    nxt_reg, nxt_next;
    logic [1:0]        stat_reg, stat_next;
    logic [12:0]       off_reg, off_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [12:0]       m_off_reg, m_off_next;

    // Scratch values.
    logic [CALC_W-1:0] need_raw;
    logic [CALC_W-1:0] start_w;
    logic [CALC_W-1:0] end_w;
    logic [CALC_W-1:0] end_g;
    logic [CALC_W-1:0] split_g;

    always_ff @(posedge aclk) begin
        if (we_mk) begin
            mem_mk[wa_mk] <= wd_mk;
        end
        if (we_ln) begin
            mem_ln[wa_ln] <= wd_ln;
        end
        if (we_nx) begin
            mem_nx[wa_nx] <= wd_nx;
        end
        if (we_pv) begin
            mem_pv[wa_pv] <= wd_pv;
        end
        rd_mk_reg <= mem_mk[rd_addr];
        rd_ln_reg <= mem_ln[rd_addr];
        rd_nx_reg <= mem_nx[rd_addr];
        rd_pv_reg <= mem_pv[rd_addr];
    end

    always_comb begin
        need_raw = ((CALC_W'(req_reg) + C_HDR + C_ALIGN - CALC_W'(1)) / C_ALIGN)
                   * C_ALIGN;
        start_w  = CALC_W'(doff_reg) - C_HDR;
        end_w    = CALC_W'(cur_reg) * C_ALIGN + CALC_W'(rd_ln_reg);
        end_g    = end_w / C_ALIGN;
        split_g  = CALC_W'(cur_reg) + need_reg / C_ALIGN;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        head_next     = head_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        req_next      = req_reg;
        doff_next     = doff_reg;
        need_next     = need_reg;
        cur_next      = cur_reg;
        guard_next    = guard_reg;
        len_next      = len_reg;
        tlen_next     = tlen_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        t_next        = t_reg;
        nxt_next      = nxt_reg;
        stat_next     = stat_reg;
        off_next      = off_reg;
        m_status_next = m_status_reg;
        m_off_next    = m_off_reg;

        rd_addr = cur_reg[GW-1:0];
        we_mk = 1'b0; wa_mk = cur_reg[GW-1:0]; wd_mk = MK_NONE;
        we_ln = 1'b0; wa_ln = cur_reg[GW-1:0]; wd_ln = '0;
        we_nx = 1'b0; wa_nx = cur_reg[GW-1:0]; wd_nx = NIL;
        we_pv = 1'b0; wa_pv = cur_reg[GW-1:0]; wd_pv = NIL;

        s_ready = (state_reg == S_IDLE);

        // Drop the result beat once taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                // Sweep every granule; granule zero holds the whole arena.
                we_mk = 1'b1; wa_mk = clr_reg;
                we_ln = 1'b1; wa_ln = clr_reg;
                we_nx = 1'b1; wa_nx = clr_reg;
                we_pv = 1'b1; wa_pv = clr_reg;
                if (clr_reg == '0) begin
                    wd_mk = MK_FREE;
                    wd_ln = LW'(HEAP_BYTES);
                end
                if (clr_reg == LAST_G) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + GW'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    req_next   = s_request_bytes;
                    doff_next  = s_data_offset;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                stat_next = STAT_FAIL;
                off_next  = '0;
                if (op_reg == OP_ALLOC) begin
                    if (req_reg == '0) begin
                        state_next = S_RESP;
                    end else begin
                        need_next  = (need_raw < C_MIN) ? C_MIN : need_raw;
                        cur_next   = head_reg;
                        guard_next = '0;
                        state_next = S_A_RD;
                    end
                end else if (doff_reg == '0) begin
                    state_next = S_RESP;
                end else if (CALC_W'(doff_reg) < C_HDR) begin
                    stat_next  = STAT_NOT_USED;
                    state_next = S_RESP;
                end else if (start_w >= C_HEAP || (start_w % C_ALIGN) != '0) begin
                    stat_next  = STAT_NOT_USED;
                    state_next = S_RESP;
                end else begin
                    cur_next   = LKW'(start_w / C_ALIGN);
                    rd_addr    = GW'(start_w / C_ALIGN);
                    state_next = S_F_CHK;
                end
            end

            // Allocate: walk the free list first fit.
            S_A_RD: begin
                if (cur_reg >= NIL || guard_reg > GUARD_MX) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (CALC_W'(rd_ln_reg) < need_reg) begin
                    cur_next   = rd_nx_reg;
                    guard_next = guard_reg + GDW'(1);
                    state_next = S_A_RD;
                end else begin
                    len_next   = rd_ln_reg;
                    p_next     = rd_pv_reg;
                    n_next     = rd_nx_reg;
                    state_next = S_A_UL1;
                end
            end
            S_A_UL1: begin
                if (p_reg < NIL) begin
                    we_nx = 1'b1; wa_nx = p_reg[GW-1:0]; wd_nx = n_reg;
                end else begin
                    head_next = n_reg;
                end
                if (n_reg < NIL) begin
                    we_pv = 1'b1; wa_pv = n_reg[GW-1:0]; wd_pv = p_reg;
                end
                state_next = S_A_UL2;
            end
            S_A_UL2: begin
                we_nx = 1'b1;
                we_pv = 1'b1;
                we_mk = 1'b1; wd_mk = MK_USED;
                stat_next = STAT_OK;
                off_next  = 13'(CALC_W'(cur_reg) * C_ALIGN + C_HDR);
                if (CALC_W'(len_reg) >= need_reg + C_MIN && split_g < C_GRAN) begin
                    t_next     = LKW'(split_g);
                    state_next = S_A_SP1;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_A_SP1: begin
                // Remainder becomes a free block.
                we_mk = 1'b1; wa_mk = t_reg[GW-1:0]; wd_mk = MK_FREE;
                we_ln = 1'b1; wa_ln = t_reg[GW-1:0];
                wd_ln = LW'(CALC_W'(len_reg) - need_reg);
                we_nx = 1'b1; wa_nx = t_reg[GW-1:0]; wd_nx = head_reg;
                we_pv = 1'b1; wa_pv = t_reg[GW-1:0]; wd_pv = NIL;
                state_next = S_A_SP2;
            end
            S_A_SP2: begin
                we_ln = 1'b1; wd_ln = LW'(need_reg);
                if (head_reg < NIL) begin
                    we_pv = 1'b1; wa_pv = head_reg[GW-1:0]; wd_pv = t_reg;
                end
                head_next  = t_reg;
                state_next = S_RESP;
            end

            // Free: check the marker and push to the head.
            S_F_CHK: begin
                if (rd_mk_reg != MK_USED) begin
                    stat_next  = STAT_NOT_USED;
                    state_next = S_RESP;
                end else begin
                    we_mk = 1'b1; wd_mk = MK_FREE;
                    we_nx = 1'b1; wd_nx = head_reg;
                    we_pv = 1'b1; wd_pv = NIL;
                    state_next = S_F_P2;
                end
            end
            S_F_P2: begin
                if (head_reg < NIL) begin
                    we_pv = 1'b1; wa_pv = head_reg[GW-1:0]; wd_pv = cur_reg;
                end
                head_next  = cur_reg;
                guard_next = '0;
                stat_next  = STAT_OK;
                state_next = S_C_RD;
            end

            // Coalesce pass in list order.
            S_C_RD: begin
                if (cur_reg >= NIL || guard_reg > GUARD_MX) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_C_CHK;
                end
            end
            S_C_CHK: begin
                len_next = rd_ln_reg;
                nxt_next = rd_nx_reg;
                if ((end_w % C_ALIGN) == '0 && end_g < C_GRAN &&
                    end_g != CALC_W'(cur_reg)) begin
                    t_next     = LKW'(end_g);
                    rd_addr    = GW'(end_g);
                    state_next = S_C_TCHK;
                end else begin
                    cur_next   = rd_nx_reg;
                    guard_next = guard_reg + GDW'(1);
                    state_next = S_C_RD;
                end
            end
            S_C_TCHK: begin
                if (rd_mk_reg == MK_FREE) begin
                    tlen_next  = rd_ln_reg;
                    p_next     = rd_pv_reg;
                    n_next     = rd_nx_reg;
                    state_next = S_C_M1;
                end else begin
                    cur_next   = nxt_reg;
                    guard_next = guard_reg + GDW'(1);
                    state_next = S_C_RD;
                end
            end
            S_C_M1: begin
                we_ln = 1'b1; wd_ln = LW'(len_reg + tlen_reg);
                if (p_reg < NIL) begin
                    we_nx = 1'b1; wa_nx = p_reg[GW-1:0]; wd_nx = n_reg;
                end else begin
                    head_next = n_reg;
                end
                if (n_reg < NIL) begin
                    we_pv = 1'b1; wa_pv = n_reg[GW-1:0]; wd_pv = p_reg;
                end
                state_next = S_C_M2;
            end
            S_C_M2: begin
                // Clear the absorbed block's entry.
                we_mk = 1'b1; wa_mk = t_reg[GW-1:0]; wd_mk = MK_NONE;
                we_ln = 1'b1; wa_ln = t_reg[GW-1:0]; wd_ln = '0;
                we_nx = 1'b1; wa_nx = t_reg[GW-1:0];
                we_pv = 1'b1; wa_pv = t_reg[GW-1:0];
                // Unlink rewrote our next link when the absorbed block followed us.
                cur_next   = (p_reg == cur_reg) ? n_reg : nxt_reg;
                guard_next = guard_reg + GDW'(1);
                state_next = S_C_RD;
            end

            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = stat_reg;
                    m_off_next    = off_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        req_reg      <= req_next;
        doff_reg     <= doff_next;
        need_reg     <= need_next;
        cur_reg      <= cur_next;
        guard_reg    <= guard_next;
        len_reg      <= len_next;
        tlen_reg     <= tlen_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        t_reg        <= t_next;
        nxt_reg      <= nxt_next;
        stat_reg     <= stat_next;
        off_reg      <= off_next;
        m_status_reg <= m_status_next;
        m_off_reg    <= m_off_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_offset = m_off_reg;

endmodule

`default_nettype wire

// ----- sim/first_fit_heap_allocator_checker.sv -----
// Checker for the heap allocator: shadow heap model and result beat comparison.
`timescale 1ns / 1ps

module first_fit_heap_allocator_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [0:0]  s_opcode,
    input  wire logic [15:0] s_request_bytes,
    input  wire logic [12:0] s_data_offset,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_status,
    input  wire logic [12:0] m_result_offset,
    output int               fail_count,
    output int               pending
);
    import ffha_pkg::*;

    localparam int HEAP   = 8192;
    localparam int ALIGN  = 8;
    localparam int MINB   = 32;
    localparam int HDR    = 16;
    localparam int NGRAN  = HEAP / ALIGN;
    localparam int NIL    = NGRAN;

    typedef struct packed {
        status_t     status;
        logic [12:0] offset;
    } answer_t;

    marker_t     mark [NGRAN];
    int unsigned blen [NGRAN];
    int unsigned nxt  [NGRAN];
    int unsigned prv  [NGRAN];
    int unsigned head;
    answer_t     answers [$];

    function automatic int unsigned up_align(input int unsigned x);
        return ((x + ALIGN - 1) / ALIGN) * ALIGN;
    endfunction

    function automatic void heap_init();
        for (int i = 0; i < NGRAN; i++) begin
            mark[i] = MK_NONE;
            blen[i] = 0;
            nxt[i]  = NIL;
            prv[i]  = NIL;
        end
        mark[0] = MK_FREE;
        blen[0] = HEAP;
        head    = 0;
    endfunction

    function automatic void detach(input int unsigned g);
        int unsigned p, n;
        p = prv[g];
        n = nxt[g];
        if (p < NGRAN) nxt[p] = n;
        else head = n;
        if (n < NGRAN) prv[n] = p;
        nxt[g] = NIL;
        prv[g] = NIL;
    endfunction

    function automatic void push_front(input int unsigned g);
        nxt[g] = head;
        prv[g] = NIL;
        if (head < NGRAN) prv[head] = g;
        head = g;
    endfunction

    // One pass in list order; each visited block swallows at most one neighbor.
    function automatic void merge_pass();
        int unsigned cur, guard, e, t;
        cur   = head;
        guard = 0;
        while (cur < NGRAN && guard <= NGRAN) begin
            e = cur * ALIGN + blen[cur];
            if (e % ALIGN == 0) begin
                t = e / ALIGN;
                if (t < NGRAN && t != cur && mark[t] == MK_FREE) begin
                    blen[cur] += blen[t];
                    detach(t);
                    mark[t] = MK_NONE;
                    blen[t] = 0;
                end
            end
            cur = nxt[cur];
            guard++;
        end
    endfunction

    function automatic answer_t heap_step(input opcode_t op, input int unsigned req,
                                          input int unsigned d);
        answer_t     a;
        int unsigned need, mine, cur, guard, r, start, g;
        a.status = STAT_FAIL;
        a.offset = '0;
        if (op == OP_ALLOC) begin
            if (req != 0) begin
                need  = up_align(req + HDR);
                mine  = up_align(MINB);
                cur   = head;
                guard = 0;
                if (need < mine) need = mine;
                while (cur < NGRAN && guard <= NGRAN && blen[cur] < need) begin
                    cur = nxt[cur];
                    guard++;
                end
                if (cur < NGRAN && blen[cur] >= need) begin
                    detach(cur);
                    if (blen[cur] >= need + mine) begin
                        r = cur + need / ALIGN;
                        if (r < NGRAN) begin
                            mark[r]   = MK_FREE;
                            blen[r]   = blen[cur] - need;
                            blen[cur] = need;
                            push_front(r);
                        end
                    end
                    mark[cur] = MK_USED;
                    a.status  = STAT_OK;
                    a.offset  = 13'(cur * ALIGN + HDR);
                end
            end
        end else if (d == 0) begin
            a.status = STAT_FAIL;
        end else if (d < HDR) begin
            a.status = STAT_NOT_USED;
        end else begin
            start = d - HDR;
            g     = start / ALIGN;
            if (start >= HEAP || start % ALIGN != 0 || g >= NGRAN || mark[g] != MK_USED) begin
                a.status = STAT_NOT_USED;
            end else begin
                mark[g] = MK_FREE;
                push_front(g);
                merge_pass();
                a.status = STAT_OK;
            end
        end
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            heap_init();
            answers.delete();
            fail_count = 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready) begin
                answers.push_back(heap_step(opcode_t'(s_opcode), s_request_bytes,
                                            s_data_offset));
            end
            if (m_valid && m_ready) begin
                if (answers.size() == 0) begin
                    $display("%0t: unexpected result beat status %0d offset %0d",
                             $time, m_status, m_result_offset);
                    fail_count++;
                end else begin
                    want = answers.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        fail_count++;
                    end
                    if (m_result_offset !== want.offset) begin
                        $display("%0t: result_offset expected %0d actual %0d",
                                 $time, want.offset, m_result_offset);
                        fail_count++;
                    end
                end
            end
            pending <= answers.size();
        end
    end

endmodule

// ----- sim/first_fit_heap_allocator_tb.sv -----
// Testbench top for the heap allocator: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int RANDOM_BEATS = 1430;
    localparam int CYCLE_LIMIT  = 20000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [0:0]  s_opcode;
    logic [15:0] s_request_bytes;
    logic [12:0] s_data_offset;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [12:0] m_result_offset;
    int          fail_count;
    int          pending;

    // Pacing knobs: idle chance in percent for each side, plus a long hold-off.
    int          src_idle_pct;
    int          sink_idle_pct;
    bit          sink_hold;
    int          cycle_count = 0;

    // Offsets handed out and not yet freed; drives well-formed free beats.
    logic [12:0] live_offsets [$];

    first_fit_heap_allocator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_request_bytes (s_request_bytes),
        .s_data_offset   (s_data_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_offset (m_result_offset)
    );

    first_fit_heap_allocator_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_request_bytes (s_request_bytes),
        .s_data_offset   (s_data_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_offset (m_result_offset),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Track live allocations from the result channel so frees hit real blocks.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && m_status == STAT_OK && m_result_offset != 0)
            live_offsets.push_back(m_result_offset);
    end

    // Time out a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("first_fit_heap_allocator verification failed");
            $finish;
        end
    end

    // Receiver: random idling at the falling edge, or a long hold-off when asked.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold)
                m_ready <= 1'b0;
            else
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Send one request beat; hold valid and payload until accepted.
    // Valid stays high on return; the next beat may idle it low or replace the payload, and drain() lowers it.
    task automatic send_beat(input opcode_t op, input logic [15:0] req,
                             input logic [12:0] off);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_request_bytes <= req;
        s_data_offset   <= off;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    // Free a live block chosen at random, or a random stale offset if none.
    task automatic free_live();
        int k;
        logic [12:0] off;
        if (live_offsets.size() != 0) begin
            k   = $urandom_range(live_offsets.size() - 1);
            off = live_offsets[k];
            live_offsets.delete(k);
        end else begin
            off = 13'($urandom);
        end
        send_beat(OP_FREE, 16'($urandom), off);
    endtask

    task automatic random_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            send_beat(OP_ALLOC, 16'($urandom_range(1, 300)), 13'($urandom));
        else if (pick < 48)
            send_beat(OP_ALLOC, 16'($urandom), 13'($urandom));
        else if (pick < 52)
            send_beat(OP_ALLOC, 16'($urandom_range(1, 3000)), 13'($urandom));
        else if (pick < 88)
            free_live();
        else if (pick < 94)
            send_beat(OP_FREE, 16'($urandom), 13'($urandom));
        else if (pick < 97 && live_offsets.size() != 0)
            // Misaligned offset just past a live block's offset.
            send_beat(OP_FREE, 16'($urandom),
                      live_offsets[0] + 13'($urandom_range(1, 7)));
        else
            send_beat(OP_ALLOC, 16'd0, 13'($urandom));
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_opcode        = OP_ALLOC;
        s_request_bytes = '0;
        s_data_offset   = '0;
        src_idle_pct    = 0;
        sink_idle_pct   = 0;
        sink_hold       = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, each status and each invalid free form.
        send_beat(OP_ALLOC, 16'd0, 13'd0);
        send_beat(OP_ALLOC, 16'hFFFF, 13'h1FFF);
        send_beat(OP_ALLOC, 16'd8176, 13'd0);
        send_beat(OP_FREE, 16'd0, 13'd16);
        send_beat(OP_FREE, 16'd0, 13'd16);
        send_beat(OP_ALLOC, 16'd1, 13'd0);
        send_beat(OP_ALLOC, 16'd16, 13'd0);
        send_beat(OP_ALLOC, 16'd17, 13'd0);
        send_beat(OP_ALLOC, 16'd100, 13'd0);
        send_beat(OP_FREE, 16'hFFFF, 13'd0);
        send_beat(OP_FREE, 16'd0, 13'd15);
        send_beat(OP_FREE, 16'd0, 13'd1);
        send_beat(OP_FREE, 16'd0, 13'h1FFF);
        send_beat(OP_FREE, 16'd0, 13'd52);
        send_beat(OP_FREE, 16'd0, 13'd24);
        send_beat(OP_FREE, 16'd0, 13'd48);
        send_beat(OP_FREE, 16'd0, 13'd48);
        send_beat(OP_FREE, 16'd0, 13'd16);
        send_beat(OP_FREE, 16'd0, 13'd80);
        send_beat(OP_ALLOC, 16'd8000, 13'd0);
        send_beat(OP_ALLOC, 16'd9000, 13'd0);
        drain();
        live_offsets.delete();

        // Three random phases with different pacing; after each the sender pauses until every result has come back.
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 17 : (phase == 1) ? 45 : 0;
            sink_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 17 : 0;
            for (int i = 0; i < RANDOM_BEATS / 3; i++) begin
                random_beat();
                if (phase == 1 && i == 100) begin
                    sink_hold = 1'b1;
                    fork
                        begin
                            repeat (3000) @(negedge aclk);
                            sink_hold = 1'b0;
                        end
                    join_none
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("first_fit_heap_allocator verification clean");
        else
            $display("first_fit_heap_allocator verification failed");
        $finish;
    end

endmodule

// ----- first_fit_heap_allocator.f -----
rtl/core/ffha_pkg.sv
rtl/core/first_fit_heap_allocator.sv
sim/first_fit_heap_allocator_checker.sv
sim/first_fit_heap_allocator_tb.sv
